// ----- rtl/lfcp_pkg.sv -----
package lfcp_pkg;

    // sync bytes and command letters
    localparam logic [7:0] SYNC_SHORT = 8'hAA;  // one-byte length follows
    localparam logic [7:0] SYNC_LONG  = 8'h55;  // two-byte length follows
    localparam logic [7:0] CMD_WRITE  = 8'h57;  // 'W'
    localparam logic [7:0] CMD_READ   = 8'h52;  // 'R'
    localparam logic [15:0] LEN_WRITE = 16'd9;
    localparam logic [15:0] LEN_READ  = 16'd5;

    // configuration register indexes
    localparam int CFG_IW = 2;
    localparam logic [CFG_IW-1:0] REG_CRC_ENABLE = 2'd0;
    localparam logic [CFG_IW-1:0] REG_CRC_POLY   = 2'd1;
    localparam logic [CFG_IW-1:0] REG_CRC_INIT   = 2'd2;

    // frame queue between parser and result stage
    localparam int QDEPTH = 2;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_LEN_HI  = 3'd1,
        PH_LEN_LO  = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_CRC_HI  = 3'd4,
        PH_CRC_LO  = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        KIND_WRITE   = 2'd0,
        KIND_READ    = 2'd1,
        KIND_OTHER   = 2'd2,
        KIND_CRC_ERR = 2'd3
    } t_kind;

    typedef struct packed {
        logic        crc_enable;
        logic [15:0] crc_poly;
        logic [15:0] crc_init;
    } t_cfg;

    // finished frame, as handed from parser to result stage
    typedef struct packed {
        logic [7:0]  letter;
        logic        len_is_write;
        logic        len_is_read;
        logic        crc_ok;
        logic [31:0] addr;
        logic [31:0] data;
        logic [8:0]  len;
        logic [15:0] rx_crc;
        logic [15:0] calc_crc;
    } t_rec;

    typedef struct packed {
        logic           full;
        logic           empty;
        logic [QCW-1:0] count;
    } t_qstat;

    // one byte through an MSB-first CRC-16, no reflection
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc,
                                               input logic [7:0]  b,
                                               input logic [15:0] poly);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = c[15] ? ((c << 1) ^ poly) : (c << 1);
        end
        return c;
    endfunction

endpackage

// ----- rtl/lfcp_front.sv -----
module lfcp_front #(
    parameter int MAX_PAYLOAD = 256
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_take,
    input  logic [7:0]       i_rx_byte,
    input  lfcp_pkg::t_cfg   i_cfg,
    output logic             o_rec_valid,
    output lfcp_pkg::t_rec   o_rec
);

    localparam int CW = $clog2(MAX_PAYLOAD + 1);
    localparam logic [16:0] MAX_LEN = 17'(MAX_PAYLOAD);

    lfcp_pkg::t_phase r_phase, n_phase;
    logic [15:0]   r_frame_length, n_frame_length;
    logic [CW-1:0] r_bytes_taken, n_bytes_taken;
    logic [15:0]   r_crc, n_crc;
    logic [7:0]    r_crc_hi, n_crc_hi;
    logic [7:0]    r_letter, n_letter;
    logic [31:0]   r_addr, n_addr;
    logic [31:0]   r_data, n_data;

    logic [15:0] v_len;
    logic [15:0] v_rx_crc;
    logic        v_emit;
    logic        v_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= lfcp_pkg::PH_HUNT;
            r_bytes_taken <= '0;
        end else begin
            r_phase       <= n_phase;
            r_bytes_taken <= n_bytes_taken;
        end
    end

    always_ff @(posedge i_clk) begin
        r_frame_length <= n_frame_length;
        r_crc          <= n_crc;
        r_crc_hi       <= n_crc_hi;
        r_letter       <= n_letter;
        r_addr         <= n_addr;
        r_data         <= n_data;
    end

    always_comb begin
        n_phase        = r_phase;
        n_frame_length = r_frame_length;
        n_bytes_taken  = r_bytes_taken;
        n_crc          = r_crc;
        n_crc_hi       = r_crc_hi;
        n_letter       = r_letter;
        n_addr         = r_addr;
        n_data         = r_data;
        v_len          = r_frame_length | {8'h00, i_rx_byte};
        v_rx_crc       = '0;
        v_emit         = 1'b0;
        v_ok           = 1'b1;
        if (i_take) begin
            case (r_phase)
                lfcp_pkg::PH_HUNT: begin
                    n_frame_length = '0;
                    n_bytes_taken  = '0;
                    if (i_rx_byte == lfcp_pkg::SYNC_SHORT) begin
                        n_phase = lfcp_pkg::PH_LEN_LO;
                    end else if (i_rx_byte == lfcp_pkg::SYNC_LONG) begin
                        n_phase = lfcp_pkg::PH_LEN_HI;
                    end
                end
                lfcp_pkg::PH_LEN_HI: begin
                    n_frame_length = {i_rx_byte, 8'h00};
                    n_phase        = lfcp_pkg::PH_LEN_LO;
                end
                lfcp_pkg::PH_LEN_LO: begin
                    n_frame_length = v_len;
                    if (v_len != '0 && {1'b0, v_len} <= MAX_LEN) begin
                        n_phase       = lfcp_pkg::PH_PAYLOAD;
                        n_bytes_taken = '0;
                        n_crc         = i_cfg.crc_init;
                        n_letter      = '0;
                        n_addr        = '0;
                        n_data        = '0;
                    end else begin
                        n_phase = lfcp_pkg::PH_HUNT;
                    end
                end
                lfcp_pkg::PH_PAYLOAD: begin
                    n_crc = lfcp_pkg::crc16_byte(r_crc, i_rx_byte, i_cfg.crc_poly);
                    if (r_bytes_taken == '0) begin
                        n_letter = i_rx_byte;
                    end else if (r_bytes_taken <= CW'(4)) begin
                        n_addr = {r_addr[23:0], i_rx_byte};
                    end else if (r_bytes_taken <= CW'(8)) begin
                        n_data = {r_data[23:0], i_rx_byte};
                    end
                    n_bytes_taken = r_bytes_taken + CW'(1);
                    if (16'(n_bytes_taken) == r_frame_length) begin
                        if (i_cfg.crc_enable) begin
                            n_phase = lfcp_pkg::PH_CRC_HI;
                        end else begin
                            n_phase = lfcp_pkg::PH_HUNT;
                            v_emit  = 1'b1;
                        end
                    end
                end
                lfcp_pkg::PH_CRC_HI: begin
                    n_crc_hi = i_rx_byte;
                    n_phase  = lfcp_pkg::PH_CRC_LO;
                end
                lfcp_pkg::PH_CRC_LO: begin
                    v_rx_crc = {r_crc_hi, i_rx_byte};
                    v_ok     = (v_rx_crc == r_crc);
                    v_emit   = 1'b1;
                    n_phase  = lfcp_pkg::PH_HUNT;
                end
                default: begin
                    n_phase = lfcp_pkg::PH_HUNT;
                end
            endcase
        end
    end

    // frame record built from the post-byte view of the state
    always_comb begin
        o_rec_valid        = v_emit;
        o_rec.letter       = n_letter;
        o_rec.len_is_write = (r_frame_length == lfcp_pkg::LEN_WRITE);
        o_rec.len_is_read  = (r_frame_length == lfcp_pkg::LEN_READ);
        o_rec.crc_ok       = v_ok;
        o_rec.addr         = n_addr;
        o_rec.data         = n_data;
        o_rec.len          = r_frame_length[8:0];
        o_rec.rx_crc       = v_rx_crc;
        o_rec.calc_crc     = n_crc;
    end

endmodule

// ----- rtl/lfcp_queue.sv -----
module lfcp_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  lfcp_pkg::t_rec   i_wr_rec,
    input  logic             i_rd,
    output lfcp_pkg::t_rec   o_rd_rec,
    output lfcp_pkg::t_qstat o_stat
);

    localparam int D = lfcp_pkg::QDEPTH;
    localparam int AW = lfcp_pkg::QAW;
    localparam int CW = lfcp_pkg::QCW;

    lfcp_pkg::t_rec r_slot [D];
    logic [AW-1:0] r_wp, n_wp;
    logic [AW-1:0] r_rp, n_rp;
    logic [CW-1:0] r_count, n_count;
    logic          v_wr, v_rd;

    assign v_wr = i_wr && (r_count != CW'(D));
    assign v_rd = i_rd && (r_count != '0);

    always_comb begin
        n_wp    = r_wp;
        n_rp    = r_rp;
        n_count = r_count;
        if (v_wr) begin
            n_wp = (r_wp == AW'(D - 1)) ? '0 : r_wp + AW'(1);
        end
        if (v_rd) begin
            n_rp = (r_rp == AW'(D - 1)) ? '0 : r_rp + AW'(1);
        end
        if (v_wr && !v_rd) begin
            n_count = r_count + CW'(1);
        end else if (v_rd && !v_wr) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (v_wr) begin
            r_slot[r_wp] <= i_wr_rec;
        end
    end

    assign o_rd_rec     = r_slot[r_rp];
    assign o_stat.full  = (r_count == CW'(D));
    assign o_stat.empty = (r_count == '0);
    assign o_stat.count = r_count;

endmodule

// ----- rtl/lfcp_back.sv -----
module lfcp_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_empty,
    input  lfcp_pkg::t_rec i_q_rec,
    output logic           o_q_rd,
    input  logic           i_pop,
    output logic           o_valid,
    output logic [1:0]     o_frame_kind,
    output logic [31:0]    o_target_address,
    output logic [31:0]    o_write_value,
    output logic [8:0]     o_payload_length,
    output logic [15:0]    o_received_crc,
    output logic [15:0]    o_computed_crc
);

    logic r_valid, n_valid;
    lfcp_pkg::t_kind r_kind, v_kind;
    logic [31:0] r_addr, v_addr;
    logic [31:0] r_data, v_data;
    logic [8:0]  r_len;
    logic [15:0] r_rx_crc;
    logic [15:0] r_calc_crc;
    logic        v_load;

    // classify the head frame
    always_comb begin
        v_kind = lfcp_pkg::KIND_OTHER;
        v_addr = '0;
        v_data = '0;
        if (!i_q_rec.crc_ok) begin
            v_kind = lfcp_pkg::KIND_CRC_ERR;
        end else if (i_q_rec.letter == lfcp_pkg::CMD_WRITE && i_q_rec.len_is_write) begin
            v_kind = lfcp_pkg::KIND_WRITE;
            v_addr = i_q_rec.addr;
            v_data = i_q_rec.data;
        end else if (i_q_rec.letter == lfcp_pkg::CMD_READ && i_q_rec.len_is_read) begin
            v_kind = lfcp_pkg::KIND_READ;
            v_addr = i_q_rec.addr;
        end
    end

    assign v_load  = !i_q_empty && (!r_valid || i_pop);
    assign o_q_rd  = v_load;
    assign n_valid = v_load || (r_valid && !i_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (v_load) begin
            r_kind     <= v_kind;
            r_addr     <= v_addr;
            r_data     <= v_data;
            r_len      <= i_q_rec.len;
            r_rx_crc   <= i_q_rec.rx_crc;
            r_calc_crc <= i_q_rec.calc_crc;
        end
    end

    assign o_valid          = r_valid;
    assign o_frame_kind     = r_kind;
    assign o_target_address = r_addr;
    assign o_write_value    = r_data;
    assign o_payload_length = r_len;
    assign o_received_crc   = r_rx_crc;
    assign o_computed_crc   = r_calc_crc;

endmodule

// ----- rtl/length_framed_command_parser.sv -----
// Channel   Handshake            Payload
// -------   ------------------   ----------------------------------------------
// byte in   push / full          i_rx_byte
// frame out empty / pop          o_frame_kind, o_target_address, o_write_value,
//                                o_payload_length, o_received_crc, o_computed_crc
// config    i_cfg_we             i_cfg_index, i_cfg_wdata
//
// One byte transaction per cycle while full is low; one byte-wide CRC-16 update
// per clock while payload bytes are taken. Taking a frame's last byte writes the
// frame queue; the output register loads the head frame when empty or popped.
// Reset (sync, active low): hunt mode, queue and output empty, crc_enable=1,
// poly=0x1021, init=0xFFFF.
// full follows the two-entry frame queue, which fills only behind a held-off pop.
module length_framed_command_parser #(
    parameter int MAX_PAYLOAD = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte stream
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_rx_byte,
    // frame results
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  o_frame_kind,
    output logic [31:0] o_target_address,
    output logic [31:0] o_write_value,
    output logic [8:0]  o_payload_length,
    output logic [15:0] o_received_crc,
    output logic [15:0] o_computed_crc,
    // config writes
    input  logic                        i_cfg_we,
    input  logic [lfcp_pkg::CFG_IW-1:0] i_cfg_index,
    input  logic [15:0]                 i_cfg_wdata
);

    logic        r_crc_enable;
    logic [15:0] r_crc_poly;
    logic [15:0] r_crc_init;

    lfcp_pkg::t_cfg   w_cfg;
    lfcp_pkg::t_rec   w_front_rec;
    lfcp_pkg::t_rec   w_q_rec;
    lfcp_pkg::t_qstat w_q_stat;
    logic             w_take;
    logic             w_front_valid;
    logic             w_q_rd;
    logic             w_out_valid;

    // Config registers. Index 3 is unused and dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc_enable <= 1'b1;
            r_crc_poly   <= 16'h1021;
            r_crc_init   <= 16'hFFFF;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                lfcp_pkg::REG_CRC_ENABLE: r_crc_enable <= i_cfg_wdata[0];
                lfcp_pkg::REG_CRC_POLY:   r_crc_poly   <= i_cfg_wdata;
                lfcp_pkg::REG_CRC_INIT:   r_crc_init   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign w_cfg.crc_enable = r_crc_enable;
    assign w_cfg.crc_poly   = r_crc_poly;
    assign w_cfg.crc_init   = r_crc_init;

    // a byte transaction happens on push with room in the frame queue
    assign full   = w_q_stat.full;
    assign w_take = push && !w_q_stat.full;

    // front: sync hunt, length, payload capture, CRC
    lfcp_front #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_take     (w_take),
        .i_rx_byte  (i_rx_byte),
        .i_cfg      (w_cfg),
        .o_rec_valid(w_front_valid),
        .o_rec      (w_front_rec)
    );

    // short queue of finished frames
    lfcp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_front_valid),
        .i_wr_rec(w_front_rec),
        .i_rd    (w_q_rd),
        .o_rd_rec(w_q_rec),
        .o_stat  (w_q_stat)
    );

    // back: classification and output register
    lfcp_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_empty       (w_q_stat.empty),
        .i_q_rec         (w_q_rec),
        .o_q_rd          (w_q_rd),
        .i_pop           (pop),
        .o_valid         (w_out_valid),
        .o_frame_kind    (o_frame_kind),
        .o_target_address(o_target_address),
        .o_write_value   (o_write_value),
        .o_payload_length(o_payload_length),
        .o_received_crc  (o_received_crc),
        .o_computed_crc  (o_computed_crc)
    );

    assign empty = !w_out_valid;

    // full must track the queue fill exactly
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full == (32'(w_q_stat.count) == lfcp_pkg::QDEPTH))
        else $error("full flag disagrees with queue fill");

    // a write command is always a nine-byte frame
    a_write_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_frame_kind == lfcp_pkg::KIND_WRITE) |-> o_payload_length == 9'd9)
        else $error("write command with wrong length");

    // only write commands carry data
    a_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_frame_kind != lfcp_pkg::KIND_WRITE) |-> o_write_value == '0)
        else $error("write data on a non-write frame");

    // a frame leaving the queue always lands in the output register
    a_queue_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_rd |=> !empty)
        else $error("dequeued frame lost");

endmodule

// ----- test/length_framed_command_parser_tb.sv -----
`timescale 1ns / 100ps

module length_framed_command_parser_tb;

    localparam int MAX_PAYLOAD   = 256;
    localparam int STALL_LIMIT   = 2000;  // cycles with no transaction on either side
    localparam int HOLD_CYCLES   = 300;   // long receiver hold-off for the fill-up test
    localparam int SETTLE_CYCLES = 4;     // parser + frame queue + output register, padded
    localparam int DIR_ROWS      = 31;
    localparam int DIR_SPLIT     = 20;    // CRC is switched off before this row

    // one finished frame as seen on the result ports
    typedef struct packed {
        lfcp_pkg::t_kind kind;
        logic [31:0]     addr;
        logic [31:0]     wval;
        logic [8:0]      plen;
        logic [15:0]     rcrc;
        logic [15:0]     ccrc;
    } t_frame_res;

    // directed script: literal byte, or the CRC the parser is holding right now
    typedef enum logic [1:0] {
        ROW_LIT,
        ROW_CRC_HI,
        ROW_CRC_LO
    } t_row_op;

    typedef struct packed {
        t_row_op         op;
        logic [7:0]      val;
        logic            pin;   // expected kind typed in below
        lfcp_pkg::t_kind kind;
    } t_script_row;

    t_script_row script [DIR_ROWS] = '{
        // stray byte while hunting
        '{ROW_LIT, 8'hFF, 1'b0, lfcp_pkg::KIND_OTHER},
        // zero length, short sync
        '{ROW_LIT, 8'hAA, 1'b0, lfcp_pkg::KIND_OTHER},
        '{ROW_LIT, 8'h00, 1'b0, lfcp_pkg::KIND_OTHER},
        // length 257 via long sync, one past the limit
        '{ROW_LIT, 8'h55, 1'b0, lfcp_pkg::KIND_OTHER},
        '{ROW_LIT, 8'h01, 1'b0, lfcp_pkg::KIND_OTHER},
        '{ROW_LIT, 8'h01, 1'b0, lfcp_pkg::KIND_OTHER},
        // read command with a good CRC
        '{ROW_LIT, 8'hAA, 1'b0, lfcp_pkg::KIND_OTHER},
        '{ROW_LIT, 8'h05, 1'b0, lfcp_pkg::KIND_OTHER},
        '{ROW_LIT, 8'h52, 1'b0, lfcp_pkg::KIND_OTHER},
        '{ROW_LIT, 8'hDE, 1'b0, lfcp_pkg::KIND_OTHER},
        '{ROW_LIT, 8'hAD, 1'b0, lfcp_pkg::KIND_OTHER},
        '{ROW_LIT, 8'hBE, 1'b0, lfcp_pkg::KIND_OTHER},
        '{ROW_LIT, 8'hEF, 1'b0, lfcp_pkg::KIND_OTHER},
        '{ROW_CRC_HI, 8'h00, 1'b0, lfcp_pkg::KIND_OTHER},
        '{ROW_CRC_LO, 8'h00, 1'b1, lfcp_pkg::KIND_READ},
        // one-byte frame with a zero CRC: mismatch
        '{ROW_LIT, 8'hAA, 1'b0, lfcp_pkg::KIND_OTHER},
        '{ROW_LIT, 8'h01, 1'b0, lfcp_pkg::KIND_OTHER},
        '{ROW_LIT, 8'h57, 1'b0, lfcp_pkg::KIND_OTHER},
        '{ROW_LIT, 8'h00, 1'b0, lfcp_pkg::KIND_OTHER},
        '{ROW_LIT, 8'h00, 1'b1, lfcp_pkg::KIND_CRC_ERR},
        // CRC off from here: write, all-ones address, all-zeros data
        '{ROW_LIT, 8'hAA, 1'b0, lfcp_pkg::KIND_OTHER},
        '{ROW_LIT, 8'h09, 1'b0, lfcp_pkg::KIND_OTHER},
        '{ROW_LIT, 8'h57, 1'b0, lfcp_pkg::KIND_OTHER},
        '{ROW_LIT, 8'hFF, 1'b0, lfcp_pkg::KIND_OTHER},
        '{ROW_LIT, 8'hFF, 1'b0, lfcp_pkg::KIND_OTHER},
        '{ROW_LIT, 8'hFF, 1'b0, lfcp_pkg::KIND_OTHER},
        '{ROW_LIT, 8'hFF, 1'b0, lfcp_pkg::KIND_OTHER},
        '{ROW_LIT, 8'h00, 1'b0, lfcp_pkg::KIND_OTHER},
        '{ROW_LIT, 8'h00, 1'b0, lfcp_pkg::KIND_OTHER},
        '{ROW_LIT, 8'h00, 1'b0, lfcp_pkg::KIND_OTHER},
        '{ROW_LIT, 8'h00, 1'b1, lfcp_pkg::KIND_WRITE}
    };

    // DUT ports
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  i_rx_byte = 8'h00;
    logic        empty;
    logic        pop = 1'b0;
    logic [1:0]  o_frame_kind;
    logic [31:0] o_target_address;
    logic [31:0] o_write_value;
    logic [8:0]  o_payload_length;
    logic [15:0] o_received_crc;
    logic [15:0] o_computed_crc;
    logic                          i_cfg_we = 1'b0;
    logic [lfcp_pkg::CFG_IW-1:0]   i_cfg_index = lfcp_pkg::REG_CRC_ENABLE;
    logic [15:0]                   i_cfg_wdata = 16'h0000;

    // configuration as the block holds it
    bit          cfg_crc_on;
    logic [15:0] cfg_poly;
    logic [15:0] cfg_init;

    // parser state mirror
    lfcp_pkg::t_phase p_phase;
    logic [15:0] p_len;
    logic [15:0] p_count;
    logic [15:0] p_crc;
    logic [7:0]  p_crc_hi;
    logic [7:0]  p_letter;
    logic [31:0] p_addr;
    logic [31:0] p_data;

    t_frame_res frames_due [$];   // results predicted, oldest first
    int         fail_count = 0;
    int         items_fed = 0;
    int         stuck_cycles = 0;

    // idling control; main process writes, monitor reads
    bit gappy = 1'b1;
    bit quiet = 1'b0;
    int hold_reqs = 0;

    // monitor-owned
    int hold_seen = 0;
    int hold_left = 0;
    int stall_left = 0;

    length_framed_command_parser #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .push             (push),
        .full             (full),
        .i_rx_byte        (i_rx_byte),
        .empty            (empty),
        .pop              (pop),
        .o_frame_kind     (o_frame_kind),
        .o_target_address (o_target_address),
        .o_write_value    (o_write_value),
        .o_payload_length (o_payload_length),
        .o_received_crc   (o_received_crc),
        .o_computed_crc   (o_computed_crc),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_wdata      (i_cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // MSB-first CRC-16 over one byte, no reflection
    function automatic logic [15:0] crc_next(input logic [15:0] c, input logic [7:0] b,
                                             input logic [15:0] poly);
        logic [15:0] r;
        r = c ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (r[15])
                r = {r[14:0], 1'b0} ^ poly;
            else
                r = {r[14:0], 1'b0};
        end
        return r;
    endfunction

    task automatic reset_mirror();
        cfg_crc_on = 1'b1;
        cfg_poly   = 16'h1021;
        cfg_init   = 16'hFFFF;
        p_phase    = lfcp_pkg::PH_HUNT;
        p_len      = '0;
        p_count    = '0;
        p_crc      = '0;
        p_crc_hi   = '0;
        p_letter   = '0;
        p_addr     = '0;
        p_data     = '0;
    endtask

    function automatic t_frame_res classify(input logic [15:0] rcrc, input bit crc_ok);
        t_frame_res r;
        r = '0;
        if (!crc_ok) begin
            r.kind = lfcp_pkg::KIND_CRC_ERR;
        end else if (p_letter == lfcp_pkg::CMD_WRITE && p_len == lfcp_pkg::LEN_WRITE) begin
            r.kind = lfcp_pkg::KIND_WRITE;
            r.addr = p_addr;
            r.wval = p_data;
        end else if (p_letter == lfcp_pkg::CMD_READ && p_len == lfcp_pkg::LEN_READ) begin
            r.kind = lfcp_pkg::KIND_READ;
            r.addr = p_addr;
        end else begin
            r.kind = lfcp_pkg::KIND_OTHER;
        end
        r.plen = p_len[8:0];
        r.rcrc = rcrc;
        r.ccrc = p_crc;
        return r;
    endfunction

    // advance the mirror by one accepted byte; got is set when a frame ends
    task automatic parse_byte(input logic [7:0] b, output bit got, output t_frame_res res);
        logic [15:0] rc;
        got = 1'b0;
        res = '0;
        case (p_phase)
            lfcp_pkg::PH_HUNT: begin
                p_len   = '0;
                p_count = '0;
                if (b == lfcp_pkg::SYNC_SHORT)
                    p_phase = lfcp_pkg::PH_LEN_LO;
                else if (b == lfcp_pkg::SYNC_LONG)
                    p_phase = lfcp_pkg::PH_LEN_HI;
            end
            lfcp_pkg::PH_LEN_HI: begin
                p_len   = {b, 8'h00};
                p_phase = lfcp_pkg::PH_LEN_LO;
            end
            lfcp_pkg::PH_LEN_LO: begin
                p_len = p_len | {8'h00, b};
                if (p_len != 0 && p_len <= MAX_PAYLOAD) begin
                    p_phase  = lfcp_pkg::PH_PAYLOAD;
                    p_count  = '0;
                    p_crc    = cfg_init;    // init latched at payload start
                    p_letter = '0;
                    p_addr   = '0;
                    p_data   = '0;
                end else begin
                    p_phase = lfcp_pkg::PH_HUNT;
                end
            end
            lfcp_pkg::PH_PAYLOAD: begin
                p_crc = crc_next(p_crc, b, cfg_poly);   // poly used live
                if (p_count == 0)
                    p_letter = b;
                else if (p_count <= 4)
                    p_addr = {p_addr[23:0], b};
                else if (p_count <= 8)
                    p_data = {p_data[23:0], b};
                p_count = p_count + 16'd1;
                if (p_count == p_len) begin
                    if (cfg_crc_on) begin
                        p_phase = lfcp_pkg::PH_CRC_HI;
                    end else begin
                        p_phase = lfcp_pkg::PH_HUNT;
                        got     = 1'b1;
                        res     = classify(16'h0000, 1'b1);
                    end
                end
            end
            lfcp_pkg::PH_CRC_HI: begin
                p_crc_hi = b;
                p_phase  = lfcp_pkg::PH_CRC_LO;
            end
            lfcp_pkg::PH_CRC_LO: begin
                rc      = {p_crc_hi, b};
                p_phase = lfcp_pkg::PH_HUNT;
                got     = 1'b1;
                res     = classify(rc, rc == p_crc);
            end
            default: p_phase = lfcp_pkg::PH_HUNT;
        endcase
    endtask

    // offer one byte and return at the edge that takes it
    task automatic offer_byte(input logic [7:0] b);
        if (gappy && !quiet && $urandom_range(0, 4) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        push      <= 1'b1;
        i_rx_byte <= b;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
    endtask

    task automatic feed_byte(input logic [7:0] b, input bit pin,
                             input lfcp_pkg::t_kind pkind);
        bit         got;
        t_frame_res res;
        offer_byte(b);
        items_fed++;
        parse_byte(b, got, res);
        if (pin) begin
            res.kind = pkind;
            got      = 1'b1;
        end
        if (got)
            frames_due.push_back(res);
    endtask

    // wait until every predicted frame is out and the parser has caught up
    task automatic settle();
        push <= 1'b0;
        while (frames_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_config(input bit en, input logic [15:0] poly, input logic [15:0] init);
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= lfcp_pkg::REG_CRC_ENABLE;
        i_cfg_wdata <= {15'd0, en};
        @(posedge i_clk);
        i_cfg_index <= lfcp_pkg::REG_CRC_POLY;
        i_cfg_wdata <= poly;
        @(posedge i_clk);
        i_cfg_index <= lfcp_pkg::REG_CRC_INIT;
        i_cfg_wdata <= init;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cfg_crc_on = en;
        cfg_poly   = poly;
        cfg_init   = init;
    endtask

    // one random chunk of traffic: mostly good frames, some noise and broken frames
    task automatic random_traffic();
        int unsigned pick;
        int unsigned r2;
        int unsigned cut;
        logic [15:0] len;
        logic [7:0]  letter;
        logic [7:0]  matching;
        logic [7:0]  b;
        logic [15:0] c;
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            repeat ($urandom_range(1, 3))
                feed_byte(8'($urandom_range(0, 255)), 1'b0, lfcp_pkg::KIND_OTHER);
        end else if (pick < 18) begin
            // lengths that send the parser back to hunting
            case ($urandom_range(0, 3))
                0: begin
                    feed_byte(lfcp_pkg::SYNC_SHORT, 1'b0, lfcp_pkg::KIND_OTHER);
                    feed_byte(8'h00, 1'b0, lfcp_pkg::KIND_OTHER);
                end
                1: begin
                    feed_byte(lfcp_pkg::SYNC_LONG, 1'b0, lfcp_pkg::KIND_OTHER);
                    feed_byte(8'h00, 1'b0, lfcp_pkg::KIND_OTHER);
                    feed_byte(8'h00, 1'b0, lfcp_pkg::KIND_OTHER);
                end
                2: begin
                    feed_byte(lfcp_pkg::SYNC_LONG, 1'b0, lfcp_pkg::KIND_OTHER);
                    feed_byte(8'h01, 1'b0, lfcp_pkg::KIND_OTHER);
                    feed_byte(8'h01, 1'b0, lfcp_pkg::KIND_OTHER);
                end
                default: begin
                    feed_byte(lfcp_pkg::SYNC_LONG, 1'b0, lfcp_pkg::KIND_OTHER);
                    feed_byte(8'($urandom_range(2, 255)), 1'b0, lfcp_pkg::KIND_OTHER);
                    feed_byte(8'($urandom_range(0, 255)), 1'b0, lfcp_pkg::KIND_OTHER);
                end
            endcase
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 30)
                len = lfcp_pkg::LEN_WRITE;
            else if (pick < 60)
                len = lfcp_pkg::LEN_READ;
            else if (pick < 61)
                len = 16'(MAX_PAYLOAD);
            else if (pick < 62)
                len = 16'($urandom_range(17, MAX_PAYLOAD - 1));
            else
                len = 16'($urandom_range(1, 16));
            matching = (len == lfcp_pkg::LEN_READ) ? lfcp_pkg::CMD_READ : lfcp_pkg::CMD_WRITE;
            r2 = $urandom_range(0, 3);
            if (r2 == 0)
                letter = 8'($urandom_range(0, 255));
            else if (r2 == 1)
                letter = (matching == lfcp_pkg::CMD_READ) ? lfcp_pkg::CMD_WRITE
                                                          : lfcp_pkg::CMD_READ;
            else
                letter = matching;
            if (len < 256 && $urandom_range(0, 1) == 1) begin
                feed_byte(lfcp_pkg::SYNC_SHORT, 1'b0, lfcp_pkg::KIND_OTHER);
                feed_byte(len[7:0], 1'b0, lfcp_pkg::KIND_OTHER);
            end else begin
                feed_byte(lfcp_pkg::SYNC_LONG, 1'b0, lfcp_pkg::KIND_OTHER);
                feed_byte(len[15:8], 1'b0, lfcp_pkg::KIND_OTHER);
                feed_byte(len[7:0], 1'b0, lfcp_pkg::KIND_OTHER);
            end
            // now and then the frame is cut short and the next one runs into it
            cut = ($urandom_range(0, 19) == 0) ? $urandom_range(0, len - 1) : len;
            c = cfg_init;
            for (int k = 0; k < cut; k++) begin
                b = (k == 0) ? letter : 8'($urandom_range(0, 255));
                c = crc_next(c, b, cfg_poly);
                feed_byte(b, 1'b0, lfcp_pkg::KIND_OTHER);
            end
            if (cut == len && cfg_crc_on) begin
                if ($urandom_range(0, 6) == 0)
                    c = c ^ (16'h0001 << $urandom_range(0, 15));
                feed_byte(c[15:8], 1'b0, lfcp_pkg::KIND_OTHER);
                feed_byte(c[7:0], 1'b0, lfcp_pkg::KIND_OTHER);
            end
        end
    endtask

    task automatic field_check(input string fname, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %h got %h", $time, fname, want, got);
            fail_count++;
        end
    endtask

    // Result side: check each transaction, then pick pop for the next cycle.
    // A long hold-off is requested by the main process through hold_reqs and
    // counted down here.
    always @(posedge i_clk) begin
        t_frame_res want;
        if (i_rst_n && pop && !empty) begin
            if (frames_due.size() == 0) begin
                $display("%0t: result with no frame pending: kind %0d addr %h len %0d",
                         $time, o_frame_kind, o_target_address, o_payload_length);
                fail_count++;
            end else begin
                want = frames_due.pop_front();
                field_check("frame_kind", 32'(want.kind), 32'(o_frame_kind));
                field_check("target_address", want.addr, o_target_address);
                field_check("write_value", want.wval, o_write_value);
                field_check("payload_length", 32'(want.plen), 32'(o_payload_length));
                field_check("received_crc", 32'(want.rcrc), 32'(o_received_crc));
                field_check("computed_crc", 32'(want.ccrc), 32'(o_computed_crc));
            end
        end
        if (hold_seen != hold_reqs) begin
            hold_seen = hold_reqs;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            pop <= 1'b0;
        end else if (gappy && !quiet && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 4) - 1;
            pop <= 1'b0;
        end else begin
            pop <= 1'b1;
        end
    end

    // watchdog: too long without a transaction on either side
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        int         phase_end;
        logic [7:0] b;
        reset_mirror();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed script, reset configuration first
        for (int r = 0; r < DIR_ROWS; r++) begin
            if (r == DIR_SPLIT)
                load_config(1'b0, 16'h8005, 16'h0000);
            case (script[r].op)
                ROW_CRC_HI: b = p_crc[15:8];
                ROW_CRC_LO: b = p_crc[7:0];
                default:    b = script[r].val;
            endcase
            feed_byte(b, script[r].pin, script[r].kind);
        end

        // random phases; the parser may be mid-frame at each config change
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: load_config(1'b1, 16'hFFFF, 16'h0000);
                1: load_config(1'b1, 16'h0000, 16'hFFFF);
                2: load_config(1'b0, 16'h1021, 16'hFFFF);
                3: load_config(1'b1, 16'h1021, 16'hFFFF);
                default: load_config($urandom_range(0, 3) != 0,
                                     16'($urandom_range(0, 65535)),
                                     16'($urandom_range(0, 65535)));
            endcase
            gappy = (ph % 3 != 2);
            phase_end = items_fed + 220;
            while (items_fed < phase_end) random_traffic();
        end

        // fill-up: receiver holds off while short frames keep coming
        load_config(1'b0, 16'h1021, 16'hFFFF);
        gappy = 1'b1;
        hold_reqs++;
        repeat (40) begin
            feed_byte(lfcp_pkg::SYNC_SHORT, 1'b0, lfcp_pkg::KIND_OTHER);
            feed_byte(8'h01, 1'b0, lfcp_pkg::KIND_OTHER);
            feed_byte(8'($urandom_range(0, 255)), 1'b0, lfcp_pkg::KIND_OTHER);
        end

        // closing stretch at full rate on both sides
        load_config(1'b1, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
        quiet = 1'b1;
        phase_end = items_fed + 300;
        while (items_fed < phase_end) random_traffic();

        push <= 1'b0;
        while (frames_due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
